// File: design/closest_point_on_triangle_2d_assert.svh
// Assertion macros for the nearest-point-on-triangle block.
// Needs nothing else; simulation gets the checks, synthesis gets empty bodies.
`ifndef CLOSEST_POINT_ON_TRIANGLE_2D_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_2D_ASSERT_SVH
`ifndef SYNTHESIS
`define CPT2D_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("cpt2d assertion failed");
`define CPT2D_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("cpt2d forbidden condition seen");
`else
`define CPT2D_ASSERT(lbl, clk, rst_n, prop)
`define CPT2D_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: design/cpt2d_pkg.sv
// Shared constants and types of the nearest-point-on-triangle block.
// No dependencies.
package cpt2d_pkg;

	localparam int MARGIN_W = 21;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 21'd10737;
	localparam int FRAC_BITS = 30;

	localparam int EDGE_AB = 0;
	localparam int EDGE_BC = 1;
	localparam int EDGE_CA = 2;

	typedef enum logic [1:0] {
		EDGE_START,
		EDGE_END,
		EDGE_MID
	} edge_mode_t;

endpackage

// File: design/closest_point_on_triangle_2d.sv
// Nearest point of a triangle to a query point, Q16.16, fully pipelined.
// Accepts one word per cycle while the output is not stalled; the edge-offset
// divider resolves one quotient bit per pipeline stage.
// A result word that waits at the output stalls the whole pipe. Depends on
// cpt2d_pkg and closest_point_on_triangle_2d_assert.svh.
`include "closest_point_on_triangle_2d_assert.svh"

module closest_point_on_triangle_2d import cpt2d_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [MARGIN_W-1:0]           cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic signed [COORD_WIDTH-1:0] corner_a_x,
	input  logic signed [COORD_WIDTH-1:0] corner_a_z,
	input  logic signed [COORD_WIDTH-1:0] corner_b_x,
	input  logic signed [COORD_WIDTH-1:0] corner_b_z,
	input  logic signed [COORD_WIDTH-1:0] corner_c_x,
	input  logic signed [COORD_WIDTH-1:0] corner_c_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] near_x,
	output logic signed [COORD_WIDTH-1:0] near_z
);

	localparam int W   = COORD_WIDTH;
	localparam int W1  = W + 1;
	localparam int PW  = 2 * W + 2;
	localparam int SW  = 2 * W + 3;
	localparam int HW  = W + 1;
	localparam int PP  = HW + 1 + W1;
	localparam int MH  = MARGIN_W + HW;
	localparam int MD  = MARGIN_W + 2 * HW;
	localparam int IW  = 2 * W + 36;
	localparam int NW  = 3 * W + 5;
	localparam int NM  = 3 * W + 4;
	localparam int DW  = 2 * W + 3;
	localparam int ST_X1 = W + 10;
	localparam int ST_X2 = W + 11;
	localparam int ST_X4 = W + 13;
	localparam int NST   = W + 14;

	typedef struct packed {
		logic [W-1:0] px;
		logic [W-1:0] pz;
		logic [W-1:0] ax;
		logic [W-1:0] az;
		logic [W-1:0] bx;
		logic [W-1:0] bz;
		logic [W-1:0] cx;
		logic [W-1:0] cz;
	} ctx_t;

	function automatic logic signed [W1-1:0] sx(input logic [W-1:0] v);
		logic signed [W-1:0] s;
		s = $signed(v);
		sx = W1'(s);
	endfunction

	function automatic logic [W-1:0] start_x(input ctx_t c, input int k);
		case (k)
			EDGE_AB: start_x = c.ax;
			EDGE_BC: start_x = c.bx;
			default: start_x = c.cx;
		endcase
	endfunction

	function automatic logic [W-1:0] start_z(input ctx_t c, input int k);
		case (k)
			EDGE_AB: start_z = c.az;
			EDGE_BC: start_z = c.bz;
			default: start_z = c.cz;
		endcase
	endfunction

	function automatic logic [W-1:0] end_x(input ctx_t c, input int k);
		case (k)
			EDGE_AB: end_x = c.bx;
			EDGE_BC: end_x = c.cx;
			default: end_x = c.ax;
		endcase
	endfunction

	function automatic logic [W-1:0] end_z(input ctx_t c, input int k);
		case (k)
			EDGE_AB: end_z = c.bz;
			EDGE_BC: end_z = c.cz;
			default: end_z = c.az;
		endcase
	endfunction

	logic                en;
	logic [NST:1]        v_q;
	logic [MARGIN_W-1:0] margin_q;
	ctx_t                ctx_in;
	ctx_t                ctx_q [1:ST_X4];
	edge_mode_t          mode_q [5:ST_X1][3];
	logic                inside_q [8:ST_X4];

	assign en        = !v_q[NST] || out_ready;
	assign in_ready  = en;
	assign out_valid = v_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q      <= '0;
			margin_q <= MARGIN_RESET;
		end else begin
			if (cfg_we) begin
				margin_q <= cfg_wdata;
			end
			if (en) begin
				v_q <= {v_q[NST-1:1], in_valid};
			end
		end
	end

	assign ctx_in = '{px: point_x, pz: point_z, ax: corner_a_x, az: corner_a_z,
		bx: corner_b_x, bz: corner_b_z, cx: corner_c_x, cz: corner_c_z};

	// stage 2: differences
	logic signed [W1-1:0] ex_c [3], ez_c [3], rx_c [3], rz_c [3], acx_c, acz_c;
	logic signed [W1-1:0] ex_s2 [3], ez_s2 [3], rx_s2 [3], rz_s2 [3], acx_s2, acz_s2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ex_c[k] = sx(end_x(ctx_q[1], k)) - sx(start_x(ctx_q[1], k));
			ez_c[k] = sx(end_z(ctx_q[1], k)) - sx(start_z(ctx_q[1], k));
			rx_c[k] = sx(ctx_q[1].px) - sx(start_x(ctx_q[1], k));
			rz_c[k] = sx(ctx_q[1].pz) - sx(start_z(ctx_q[1], k));
		end
		acx_c = sx(ctx_q[1].cx) - sx(ctx_q[1].ax);
		acz_c = sx(ctx_q[1].cz) - sx(ctx_q[1].az);
	end

	// stage 3: products
	logic signed [PW-1:0] dd1_s3, dd2_s3, cv1_s3, cv2_s3, cw1_s3, cw2_s3;
	logic signed [PW-1:0] lx_s3 [3], lz_s3 [3], dpx_s3 [3], dpz_s3 [3];
	logic signed [W1-1:0] ex_s3 [3], ez_s3 [3];

	// stage 4: sums
	logic signed [SW-1:0] d_s4, cv_s4, cw_s4, len2_s4 [3], dp_s4 [3];
	logic signed [W1-1:0] ex_s4 [3], ez_s4 [3];

	// stage 5: orientation and edge classification
	logic signed [SW-1:0] dn_c, cvn_c, cwn_c;
	edge_mode_t           mode_c [3];
	logic signed [SW-1:0] dn_s5, cvn_s5, cwn_s5;
	logic                 dnz_s5;
	logic [PW-1:0]        dpm_s5 [3];
	logic [SW-1:0]        len2_s5 [3];
	logic signed [W1-1:0] ex_s5 [3], ez_s5 [3];

	always_comb begin
		dn_c  = d_s4[SW-1] ? -d_s4  : d_s4;
		cvn_c = d_s4[SW-1] ? -cv_s4 : cv_s4;
		cwn_c = d_s4[SW-1] ? -cw_s4 : cw_s4;
		for (int k = 0; k < 3; k++) begin
			if (len2_s4[k] == '0 || dp_s4[k][SW-1] || dp_s4[k] == '0) begin
				mode_c[k] = EDGE_START;
			end else if (dp_s4[k] >= len2_s4[k]) begin
				mode_c[k] = EDGE_END;
			end else begin
				mode_c[k] = EDGE_MID;
			end
		end
	end

	// stage 6: margin and edge partial products
	logic [MH-1:0]          md_lo_s6, md_hi_s6;
	logic signed [SW:0]     ssum_s6;
	logic signed [SW-1:0]   dn_s6, cvn_s6, cwn_s6;
	logic                   dnz_s6;
	logic [SW-1:0]          len2_s6 [3];
	logic signed [PP-1:0]   plo_s6 [6], phi_s6 [6];

	// stage 7: recombine
	logic [MD-1:0]          md_s7;
	logic signed [SW+1:0]   sd_s7;
	logic signed [SW-1:0]   cvn_s7, cwn_s7;
	logic                   dnz_s7;
	logic [SW-1:0]          len2_s7 [3];
	logic signed [NW-1:0]   num_s7 [6];

	// stage 8: inside test and rounding dividend
	logic signed [IW-1:0]   mdx_c, t1_c, t2_c, t3_c;
	logic                   inside_c;
	logic signed [NW-1:0]   n2_s8 [6];
	logic [DW-1:0]          d2_s8 [3];

	always_comb begin
		mdx_c    = IW'($signed({1'b0, md_s7}));
		t1_c     = (IW'(cvn_s7) <<< FRAC_BITS) + mdx_c;
		t2_c     = (IW'(cwn_s7) <<< FRAC_BITS) + mdx_c;
		t3_c     = (IW'(sd_s7) <<< FRAC_BITS) - mdx_c;
		inside_c = dnz_s7 && !t1_c[IW-1] && !t2_c[IW-1] && (t3_c[IW-1] || t3_c == '0);
	end

	// stage 9 and divider
	logic signed [NW-1:0] abs_c [6];
	logic [NM-1:0]        dv_rem_q [0:W][6];
	logic [W-1:0]         dv_quo_q [0:W][6];
	logic                 dv_neg_q [0:W][6];
	logic [DW-1:0]        dv_d2_q  [0:W][3];

	always_comb begin
		for (int l = 0; l < 6; l++) begin
			abs_c[l] = n2_s8[l][NW-1] ? -n2_s8[l] : n2_s8[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q[1] <= ctx_in;
			for (int i = 2; i <= ST_X4; i++) ctx_q[i] <= ctx_q[i-1];
			mode_q[5] <= mode_c;
			for (int i = 6; i <= ST_X1; i++) mode_q[i] <= mode_q[i-1];
			inside_q[8] <= inside_c;
			for (int i = 9; i <= ST_X4; i++) inside_q[i] <= inside_q[i-1];

			ex_s2  <= ex_c;
			ez_s2  <= ez_c;
			rx_s2  <= rx_c;
			rz_s2  <= rz_c;
			acx_s2 <= acx_c;
			acz_s2 <= acz_c;

			dd1_s3 <= PW'(acx_s2) * PW'(ez_s2[EDGE_AB]);
			dd2_s3 <= PW'(acz_s2) * PW'(ex_s2[EDGE_AB]);
			cv1_s3 <= PW'(rx_s2[EDGE_AB]) * PW'(ez_s2[EDGE_AB]);
			cv2_s3 <= PW'(rz_s2[EDGE_AB]) * PW'(ex_s2[EDGE_AB]);
			cw1_s3 <= PW'(acx_s2) * PW'(rz_s2[EDGE_AB]);
			cw2_s3 <= PW'(acz_s2) * PW'(rx_s2[EDGE_AB]);
			for (int k = 0; k < 3; k++) begin
				lx_s3[k]  <= PW'(ex_s2[k]) * PW'(ex_s2[k]);
				lz_s3[k]  <= PW'(ez_s2[k]) * PW'(ez_s2[k]);
				dpx_s3[k] <= PW'(rx_s2[k]) * PW'(ex_s2[k]);
				dpz_s3[k] <= PW'(rz_s2[k]) * PW'(ez_s2[k]);
			end
			ex_s3 <= ex_s2;
			ez_s3 <= ez_s2;

			d_s4  <= SW'(dd1_s3) - SW'(dd2_s3);
			cv_s4 <= SW'(cv1_s3) - SW'(cv2_s3);
			cw_s4 <= SW'(cw1_s3) - SW'(cw2_s3);
			for (int k = 0; k < 3; k++) begin
				len2_s4[k] <= SW'(lx_s3[k]) + SW'(lz_s3[k]);
				dp_s4[k]   <= SW'(dpx_s3[k]) + SW'(dpz_s3[k]);
			end
			ex_s4 <= ex_s3;
			ez_s4 <= ez_s3;

			dn_s5  <= dn_c;
			cvn_s5 <= cvn_c;
			cwn_s5 <= cwn_c;
			dnz_s5 <= d_s4 != '0;
			for (int k = 0; k < 3; k++) begin
				dpm_s5[k]  <= (mode_c[k] == EDGE_MID) ? dp_s4[k][PW-1:0] : '0;
				len2_s5[k] <= len2_s4[k];
			end
			ex_s5 <= ex_s4;
			ez_s5 <= ez_s4;

			md_lo_s6 <= MH'(margin_q) * MH'(dn_s5[HW-1:0]);
			md_hi_s6 <= MH'(margin_q) * MH'(dn_s5[2*HW-1:HW]);
			ssum_s6  <= (SW+1)'(cvn_s5) + (SW+1)'(cwn_s5);
			dn_s6    <= dn_s5;
			cvn_s6   <= cvn_s5;
			cwn_s6   <= cwn_s5;
			dnz_s6   <= dnz_s5;
			len2_s6  <= len2_s5;
			for (int k = 0; k < 3; k++) begin
				plo_s6[2*k]   <= PP'($signed({1'b0, dpm_s5[k][HW-1:0]})) * PP'(ex_s5[k]);
				phi_s6[2*k]   <= PP'($signed({1'b0, dpm_s5[k][2*HW-1:HW]})) * PP'(ex_s5[k]);
				plo_s6[2*k+1] <= PP'($signed({1'b0, dpm_s5[k][HW-1:0]})) * PP'(ez_s5[k]);
				phi_s6[2*k+1] <= PP'($signed({1'b0, dpm_s5[k][2*HW-1:HW]})) * PP'(ez_s5[k]);
			end

			md_s7   <= MD'(md_lo_s6) + (MD'(md_hi_s6) << HW);
			sd_s7   <= (SW+2)'(ssum_s6) - (SW+2)'(dn_s6);
			cvn_s7  <= cvn_s6;
			cwn_s7  <= cwn_s6;
			dnz_s7  <= dnz_s6;
			len2_s7 <= len2_s6;
			for (int l = 0; l < 6; l++) begin
				num_s7[l] <= NW'(plo_s6[l]) + (NW'(phi_s6[l]) <<< HW);
			end

			for (int l = 0; l < 6; l++) begin
				n2_s8[l] <= (num_s7[l] <<< 1) + NW'($signed({1'b0, len2_s7[l>>1]}));
			end
			for (int k = 0; k < 3; k++) begin
				d2_s8[k] <= DW'(len2_s7[k]) << 1;
			end

			for (int l = 0; l < 6; l++) begin
				dv_rem_q[0][l] <= abs_c[l][NM-1:0];
				dv_quo_q[0][l] <= '0;
				dv_neg_q[0][l] <= n2_s8[l][NW-1];
			end
			dv_d2_q[0] <= d2_s8;
		end
	end

	for (genvar j = 0; j < W; j++) begin : g_div
		logic [NM-1:0] sh [6];
		logic [NM:0]   df [6];

		always_comb begin
			for (int l = 0; l < 6; l++) begin
				sh[l] = NM'(dv_d2_q[j][l>>1]) << (W - 1 - j);
				df[l] = {1'b0, dv_rem_q[j][l]} - {1'b0, sh[l]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 6; l++) begin
					dv_rem_q[j+1][l] <= df[l][NM] ? dv_rem_q[j][l] : df[l][NM-1:0];
					dv_quo_q[j+1][l] <= {dv_quo_q[j][l][W-2:0], !df[l][NM]};
					dv_neg_q[j+1][l] <= dv_neg_q[j][l];
				end
				dv_d2_q[j+1] <= dv_d2_q[j];
			end
		end
	end

	// post-divider stages
	logic signed [W1-1:0] qq_c [6], off_c [6];
	logic signed [W1-1:0] off_sx1 [6];
	logic [W-1:0]         nx_c [3], nz_c [3];
	logic [W-1:0]         nx_sx2 [3], nz_sx2 [3];
	logic signed [W1-1:0] dx_c [3], dz_c [3];
	logic signed [PW-1:0] sqx_sx3 [3], sqz_sx3 [3];
	logic [W-1:0]         nx_sx3 [3], nz_sx3 [3];
	logic [PW:0]          dist_sx4 [3];
	logic [W-1:0]         nx_sx4 [3], nz_sx4 [3];
	logic [W-1:0]         rx_c2, rz_c2;
	logic [W-1:0]         near_x_sx5, near_z_sx5;

	always_comb begin
		for (int l = 0; l < 6; l++) begin
			qq_c[l]  = W1'(dv_quo_q[W][l]) + W1'(dv_rem_q[W][l] != '0);
			off_c[l] = dv_neg_q[W][l] ? -qq_c[l] : W1'(dv_quo_q[W][l]);
		end
		for (int k = 0; k < 3; k++) begin
			unique case (mode_q[ST_X1][k])
				EDGE_END: begin
					nx_c[k] = end_x(ctx_q[ST_X1], k);
					nz_c[k] = end_z(ctx_q[ST_X1], k);
				end
				EDGE_MID: begin
					nx_c[k] = W'(sx(start_x(ctx_q[ST_X1], k)) + off_sx1[2*k]);
					nz_c[k] = W'(sx(start_z(ctx_q[ST_X1], k)) + off_sx1[2*k+1]);
				end
				default: begin
					nx_c[k] = start_x(ctx_q[ST_X1], k);
					nz_c[k] = start_z(ctx_q[ST_X1], k);
				end
			endcase
			dx_c[k] = sx(ctx_q[ST_X2].px) - sx(nx_sx2[k]);
			dz_c[k] = sx(ctx_q[ST_X2].pz) - sx(nz_sx2[k]);
		end
		if (inside_q[ST_X4]) begin
			rx_c2 = ctx_q[ST_X4].px;
			rz_c2 = ctx_q[ST_X4].pz;
		end else if (dist_sx4[EDGE_AB] <= dist_sx4[EDGE_BC]
				&& dist_sx4[EDGE_AB] <= dist_sx4[EDGE_CA]) begin
			rx_c2 = nx_sx4[EDGE_AB];
			rz_c2 = nz_sx4[EDGE_AB];
		end else if (dist_sx4[EDGE_BC] <= dist_sx4[EDGE_CA]) begin
			rx_c2 = nx_sx4[EDGE_BC];
			rz_c2 = nz_sx4[EDGE_BC];
		end else begin
			rx_c2 = nx_sx4[EDGE_CA];
			rz_c2 = nz_sx4[EDGE_CA];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_sx1 <= off_c;
			nx_sx2  <= nx_c;
			nz_sx2  <= nz_c;
			for (int k = 0; k < 3; k++) begin
				sqx_sx3[k]  <= PW'(dx_c[k]) * PW'(dx_c[k]);
				sqz_sx3[k]  <= PW'(dz_c[k]) * PW'(dz_c[k]);
				dist_sx4[k] <= {1'b0, sqx_sx3[k]} + {1'b0, sqz_sx3[k]};
			end
			nx_sx3     <= nx_sx2;
			nz_sx3     <= nz_sx2;
			nx_sx4     <= nx_sx3;
			nz_sx4     <= nz_sx3;
			near_x_sx5 <= rx_c2;
			near_z_sx5 <= rz_c2;
		end
	end

	assign near_x = near_x_sx5;
	assign near_z = near_z_sx5;

	`CPT2D_ASSERT(a_accept_enters, clk, arst_n, in_valid && in_ready |=> v_q[1])
	`CPT2D_ASSERT(a_stall_holds, clk, arst_n, !en |=> $stable(v_q))
	`CPT2D_ASSERT_NEVER(a_mid_zero_len, clk, arst_n, v_q[5] && ((mode_q[5][EDGE_AB] == EDGE_MID && len2_s5[EDGE_AB] == '0) || (mode_q[5][EDGE_BC] == EDGE_MID && len2_s5[EDGE_BC] == '0) || (mode_q[5][EDGE_CA] == EDGE_MID && len2_s5[EDGE_CA] == '0)))

	for (genvar l = 0; l < 6; l++) begin : g_chk
		`CPT2D_ASSERT(a_rem_bound, clk, arst_n, v_q[W+9] && mode_q[W+9][l>>1] == EDGE_MID |-> dv_rem_q[W][l] < NM'(dv_d2_q[W][l>>1]))
	end

endmodule

// File: tb/sv/tb_closest_point_on_triangle_2d.sv
// Self-checking testbench for closest_point_on_triangle_2d: directed table, then random triangles.
// Predicts nearest points the table does not give with exact wide arithmetic; depends on cpt2d_pkg and the block.
`timescale 1ns / 1ps

module tb_closest_point_on_triangle_2d import cpt2d_pkg::*; ();

	localparam int CW = 32;
	localparam int LATENCY = CW + 14;
	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 1730;

	typedef logic signed [255:0] acc_t;
	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t px, pz, ax, az, bx, bz, cx, cz;
	} tri_query_t;

	typedef struct packed {
		coord_t x, z;
	} near_pt_t;

	typedef struct {
		tri_query_t q;
		bit         known;
		near_pt_t   res;
	} table_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [MARGIN_W-1:0] cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	tri_query_t          in_word;
	logic                out_valid;
	logic                out_ready;
	coord_t              near_x;
	coord_t              near_z;

	logic [MARGIN_W-1:0] margin;
	near_pt_t            near_q[$];
	int                  errors;
	int                  idle_cycles;
	bit                  long_hold;
	bit                  done;

	closest_point_on_triangle_2d #(.COORD_WIDTH(CW)) i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(in_word.px), .point_z(in_word.pz),
		.corner_a_x(in_word.ax), .corner_a_z(in_word.az),
		.corner_b_x(in_word.bx), .corner_b_z(in_word.bz),
		.corner_c_x(in_word.cx), .corner_c_z(in_word.cz),
		.out_valid(out_valid), .out_ready(out_ready),
		.near_x(near_x), .near_z(near_z)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// nearest integer to n/d, d > 0, ties toward +infinity
	function automatic acc_t round_quot(acc_t n, acc_t d);
		acc_t n2, d2, q;
		n2 = 2 * n + d;
		d2 = 2 * d;
		if (n2 >= 0)
			return n2 / d2;
		q = (-n2) / d2;
		if ((-n2) % d2 != 0)
			q = q + 1;
		return -q;
	endfunction

	function automatic void project_edge(acc_t px, acc_t pz, acc_t ax, acc_t az,
			acc_t bx, acc_t bz, output acc_t qx, output acc_t qz);
		acc_t ex, ez, len2, dp;
		ex = bx - ax;
		ez = bz - az;
		len2 = ex * ex + ez * ez;
		qx = ax;
		qz = az;
		if (len2 == 0)
			return;
		dp = (px - ax) * ex + (pz - az) * ez;
		if (dp <= 0)
			return;
		if (dp >= len2) begin
			qx = bx;
			qz = bz;
			return;
		end
		qx = ax + round_quot(dp * ex, len2);
		qz = az + round_quot(dp * ez, len2);
	endfunction

	function automatic near_pt_t nearest_point(tri_query_t t, logic [MARGIN_W-1:0] m);
		acc_t px, pz, ax, az, bx, bz, cx, cz;
		acc_t d, cv, cw, md, x1, z1, x2, z2, x3, z3, dab, dbc, dca;
		near_pt_t r;
		bit in_tri;
		px = t.px; pz = t.pz; ax = t.ax; az = t.az;
		bx = t.bx; bz = t.bz; cx = t.cx; cz = t.cz;
		in_tri = 1'b0;
		d = (cx - ax) * (bz - az) - (cz - az) * (bx - ax);
		if (d != 0) begin
			cv = (px - ax) * (bz - az) - (pz - az) * (bx - ax);
			cw = (cx - ax) * (pz - az) - (cz - az) * (px - ax);
			if (d < 0) begin
				d = -d;
				cv = -cv;
				cw = -cw;
			end
			md = acc_t'(m) * d;
			in_tri = (cv * (2 ** 30) + md >= 0) && (cw * (2 ** 30) + md >= 0)
				&& ((cv + cw) * (2 ** 30) <= d * (2 ** 30) + md);
		end
		if (in_tri) begin
			r.x = t.px;
			r.z = t.pz;
			return r;
		end
		project_edge(px, pz, ax, az, bx, bz, x1, z1);
		project_edge(px, pz, bx, bz, cx, cz, x2, z2);
		project_edge(px, pz, cx, cz, ax, az, x3, z3);
		dab = (px - x1) * (px - x1) + (pz - z1) * (pz - z1);
		dbc = (px - x2) * (px - x2) + (pz - z2) * (pz - z2);
		dca = (px - x3) * (px - x3) + (pz - z3) * (pz - z3);
		if (dab <= dbc && dab <= dca) begin
			r.x = coord_t'(x1); r.z = coord_t'(z1);
		end else if (dbc <= dca) begin
			r.x = coord_t'(x2); r.z = coord_t'(z2);
		end else begin
			r.x = coord_t'(x3); r.z = coord_t'(z3);
		end
		return r;
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 20 * 65536)) - coord_t'(10 * 65536);
			2: return coord_t'($urandom_range(0, 64)) - coord_t'(32);
			default: return ($urandom_range(0, 1)) ? coord_t'(32'h7FFF_FFFF - $urandom_range(0, 3))
				: coord_t'(32'h8000_0000 + $urandom_range(0, 3));
		endcase
	endfunction

	function automatic tri_query_t rand_query();
		tri_query_t t;
		int mode, kind;
		mode = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(0, 3);
		kind = $urandom_range(0, 9);
		t.ax = rand_coord(mode); t.az = rand_coord(mode);
		t.bx = rand_coord(mode); t.bz = rand_coord(mode);
		t.cx = rand_coord(mode); t.cz = rand_coord(mode);
		t.px = rand_coord(mode); t.pz = rand_coord(mode);
		if (kind == 0) begin
			t.bx = t.ax; t.bz = t.az;
		end else if (kind == 1) begin
			t.cx = t.bx + (t.bx - t.ax); t.cz = t.bz + (t.bz - t.az);
		end else if (kind == 2) begin
			t.px = t.ax + ((t.bx - t.ax) >>> 2) + ((t.cx - t.ax) >>> 2);
			t.pz = t.az + ((t.bz - t.az) >>> 2) + ((t.cz - t.az) >>> 2);
		end else if (kind == 3) begin
			t.px = t.ax + ((t.bx - t.ax) >>> 1) + coord_t'($urandom_range(0, 4)) - 2;
			t.pz = t.az + ((t.bz - t.az) >>> 1) + coord_t'($urandom_range(0, 4)) - 2;
		end
		return t;
	endfunction

	task automatic send_word(tri_query_t t, bit known, near_pt_t res);
		in_valid <= 1'b1;
		in_word <= t;
		near_q = {near_q, known ? res : nearest_point(t, margin)};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		while (near_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_margin(logic [MARGIN_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		margin = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic tri_query_t mk(int px, int pz, int ax, int az, int bx, int bz,
			int cx, int cz);
		tri_query_t t;
		t.px = px; t.pz = pz; t.ax = ax; t.az = az;
		t.bx = bx; t.bz = bz; t.cx = cx; t.cz = cz;
		return t;
	endfunction

	function automatic near_pt_t pt(int x, int z);
		near_pt_t r;
		r.x = x; r.z = z;
		return r;
	endfunction

	localparam int U = 65536;
	localparam int MX = 32'h7FFF_FFFF;
	localparam int MN = 32'h8000_0000;

	table_row_t directed[$];

	initial begin
		directed = '{
			'{mk(U, U, 0, 0, 4*U, 0, 0, 4*U), 1, pt(U, U)},
			'{mk(-U, -U, 0, 0, 4*U, 0, 0, 4*U), 1, pt(0, 0)},
			'{mk(9*U, -U, 0, 0, 4*U, 0, 0, 4*U), 1, pt(4*U, 0)},
			'{mk(2*U, -3*U, 0, 0, 4*U, 0, 0, 4*U), 1, pt(2*U, 0)},
			'{mk(-2*U, 2*U, 0, 0, 4*U, 0, 0, 4*U), 1, pt(0, 2*U)},
			'{mk(5*U, 5*U, 0, 0, 4*U, 0, 0, 4*U), 0, pt(0, 0)},
			'{mk(U, 2*U, 0, 0, 0, 0, 0, 0), 1, pt(0, 0)},
			'{mk(U, 2*U, 0, 0, 2*U, 0, 4*U, 0), 0, pt(0, 0)},
			'{mk(3, 1, 0, 0, 7, 0, 0, 7), 1, pt(3, 1)},
			'{mk(-1, 3, 0, 0, 7, 0, 0, 7), 0, pt(0, 0)},
			'{mk(MX, MX, MN, MN, MX, MN, MN, MX), 0, pt(0, 0)},
			'{mk(MN, MN, MX, MX, MN, MX, MX, MN), 0, pt(0, 0)},
			'{mk(MX, MN, MN, MN, MX, MX, 0, 0), 0, pt(0, 0)},
			'{mk(MN, MX, MN, MN, MN, MN, MX, MX), 0, pt(0, 0)},
			'{mk(0, 0, MX, MX, MX, MX, MX, MX), 1, pt(MX, MX)},
			'{mk(-1, -1, 1, 1, -1, 1, 1, -1), 0, pt(0, 0)},
			'{mk(7, 7, 0, 0, 3, 0, 0, 3), 0, pt(0, 0)},
			'{mk(U, 0, 0, 0, 0, 0, 2*U, 0), 0, pt(0, 0)}
		};
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_word = '0;
		margin = MARGIN_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_word(directed[i].q, directed[i].known, directed[i].res);
		in_valid <= 1'b0;
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_margin('0);
				1: write_margin(MARGIN_RESET);
				2: write_margin({MARGIN_W{1'b1}});
				3: write_margin(MARGIN_W'($urandom));
				default: write_margin(21'd1073741);
			endcase
			for (int n = 0; n < N_RANDOM / 5;) begin
				int burst;
				burst = $urandom_range(1, 40);
				for (int b = 0; b < burst && n < N_RANDOM / 5; b++, n++)
					send_word(rand_query(), 0, '0);
				if ($urandom_range(0, 1)) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			end
			in_valid <= 1'b0;
			drain();
		end
		done = 1'b1;
	end

	initial begin
		out_ready = 1'b0;
		long_hold = 1'b0;
		@(posedge arst_n);
		forever begin
			int pat;
			pat = $urandom_range(0, 9);
			if (!long_hold && near_q.size() > 30) begin
				long_hold = 1'b1;
				out_ready <= 1'b0;
				repeat (3 * LATENCY) @(posedge clk);
			end else if (pat < 4) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end else begin
				out_ready <= pat[0];
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (near_q.size() == 0) begin
				$error("unexpected word: near_x %0d near_z %0d", near_x, near_z);
				errors++;
			end else begin
				near_pt_t e;
				e = near_q.pop_front();
				if (near_x !== e.x) begin
					$error("near_x expected %0d actual %0d", e.x, near_x);
					errors++;
				end
				if (near_z !== e.z) begin
					$error("near_z expected %0d actual %0d", e.z, near_z);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		done = 1'b0;
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (done) begin
				if (errors == 0 && near_q.size() == 0)
					$display("** closest_point_on_triangle_2d: PASSED **");
				else
					$display("** closest_point_on_triangle_2d: FAILED **");
				$finish;
			end else if (idle_cycles >= WATCHDOG) begin
				$display("** closest_point_on_triangle_2d: FAILED **");
				$finish;
			end
		end
	end

endmodule

// File: closest_point_on_triangle_2d.f
+incdir+design
design/cpt2d_pkg.sv
design/closest_point_on_triangle_2d.sv
tb/sv/tb_closest_point_on_triangle_2d.sv
